FILE: rtl/core/row_offset_frame_difference_motion_assert.svh
// assertion macros for the frame difference motion block
// used by the top level only, expects i_clk and i_rst_n in scope
`ifndef ROW_OFFSET_FRAME_DIFFERENCE_MOTION_ASSERT_SVH
`define ROW_OFFSET_FRAME_DIFFERENCE_MOTION_ASSERT_SVH

// condition implies consequence in the same cycle
`define ROFDM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define ROFDM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/rofdm_pkg.sv
// shared types and constants for the frame difference motion block
// no dependencies
`default_nettype none

package rofdm_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 512;

    localparam int PIX_W   = 8;
    localparam int FW_W    = 11;
    localparam int FH_W    = 10;
    localparam int THR_W   = 8;
    localparam int COUNT_W = 20;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam logic [FW_W-1:0]    FRAME_WIDTH_RST  = FW_W'(640);
    localparam logic [FH_W-1:0]    FRAME_HEIGHT_RST = FH_W'(480);
    localparam logic [THR_W-1:0]   PIX_THR_RST      = THR_W'(40);
    localparam logic [COUNT_W-1:0] MOTION_THR_RST   = COUNT_W'(5000);
    localparam logic [COUNT_W-1:0] COUNT_MAX        = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_PIX_THR      = 2'd2,
        CFG_MOTION_THR   = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } t_state;

endpackage

`default_nettype wire

FILE: rtl/core/rofdm_if.sv
// valid/ready channel interfaces: pixel input, frame result, register write
// depends on rofdm_pkg
`default_nettype none

interface rofdm_pix_if import rofdm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_value;

    modport source (output valid, output pixel_value, input ready);
    modport sink   (input valid, input pixel_value, output ready);
endinterface

interface rofdm_res_if import rofdm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] changed_count;
    logic               motion_detected;

    modport source (output valid, output changed_count, output motion_detected, input ready);
    modport sink   (input valid, input changed_count, input motion_detected, output ready);
endinterface

interface rofdm_cfg_if import rofdm_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/rofdm_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module rofdm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/core/row_offset_frame_difference_motion.sv
// Frame difference motion detector. Takes one grayscale pixel per clock in raster order, when
// not holding pixels off, and compares it with the previous frame's pixel one row further down;
// after the last pixel of a frame it delivers the changed-pixel count and the motion flag. The
// previous-frame ram reads the pixel below and writes the current pixel in the same cycle, and
// the compare and count update take place in the compare stage, whose result goes on to the
// result register. Outside the clear, pixels are held off only while a finished result waits in
// the output register and another frame end is due behind it. After reset the ram is cleared
// one entry per cycle, all MAX_WIDTH*MAX_HEIGHT entries (524288 at the defaults), and no
// pixel is taken until then; register writes are taken at any time.
`default_nettype none

module row_offset_frame_difference_motion import rofdm_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    rofdm_cfg_if.sink   i_cfg,
    rofdm_pix_if.sink   i_pix,
    rofdm_res_if.source o_res
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int WL_W   = $clog2(MAX_WIDTH + 1);
    localparam int HL_W   = $clog2(MAX_HEIGHT + 1);
    localparam int WX_W   = (FW_W > WL_W) ? FW_W : WL_W;
    localparam int HX_W   = (FH_W > HL_W) ? FH_W : HL_W;

    // configuration
    logic [FW_W-1:0]    r_frame_width;
    logic [FH_W-1:0]    r_frame_height;
    logic [THR_W-1:0]   r_pix_thr;
    logic [COUNT_W-1:0] r_motion_thr;

    t_state             r_state;
    logic [ADDR_W-1:0]  r_clr_addr;

    logic [COL_W-1:0]   r_col;
    logic [ROW_W-1:0]   r_row;

    // compare stage
    logic               r_s1_valid;
    logic               r_s1_cmp;
    logic               r_s1_last;
    logic [PIX_W-1:0]   r_s1_pix;
    logic [COUNT_W-1:0] r_count;

    // result register
    logic               r_out_valid;
    logic [COUNT_W-1:0] r_out_count;
    logic               r_out_motion;

    logic [WX_W-1:0]    w_lim;
    logic [HX_W-1:0]    h_lim;
    logic [WX_W-1:0]    col_inc;
    logic [HX_W-1:0]    row_inc;
    logic               cmp_en;
    logic               col_end;
    logic               row_end;
    logic               pix_accept;
    logic               s1_stall;
    logic               s1_fire;
    logic [COL_W-1:0]   n_col;
    logic [ROW_W-1:0]   n_row;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  px_addr;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [PIX_W-1:0]   ram_wdata;
    logic [PIX_W-1:0]   ram_rdata;
    logic [PIX_W-1:0]   diff;
    logic               hit;
    logic [COUNT_W-1:0] n_count;

    // frame geometry, clamped to what the store holds and to at least one column and two rows
    always_comb begin
        if (WX_W'(r_frame_width) == '0) begin
            w_lim = WX_W'(1);
        end else if (WX_W'(r_frame_width) > WX_W'(MAX_WIDTH)) begin
            w_lim = WX_W'(MAX_WIDTH);
        end else begin
            w_lim = WX_W'(r_frame_width);
        end
        if (HX_W'(r_frame_height) < HX_W'(2)) begin
            h_lim = HX_W'(2);
        end else if (HX_W'(r_frame_height) > HX_W'(MAX_HEIGHT)) begin
            h_lim = HX_W'(MAX_HEIGHT);
        end else begin
            h_lim = HX_W'(r_frame_height);
        end
    end

    assign col_inc = WX_W'(r_col) + WX_W'(1);
    assign row_inc = HX_W'(r_row) + HX_W'(1);
    assign cmp_en  = row_inc < h_lim;
    assign col_end = col_inc >= w_lim;
    assign row_end = row_inc >= h_lim;

    assign s1_stall   = r_s1_valid && r_s1_last && r_out_valid && !o_res.ready;
    assign s1_fire    = r_s1_valid && !s1_stall;
    assign i_pix.ready = (r_state == ST_RUN) && !s1_stall;
    assign pix_accept = i_pix.valid && i_pix.ready;
    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (col_end) begin
            n_col = '0;
            n_row = row_end ? '0 : row_inc[ROW_W-1:0];
        end else begin
            n_col = col_inc[COL_W-1:0];
        end
    end

    // pixel below is only fetched when it lies inside the frame
    assign rd_addr = ADDR_W'(int'(row_inc[ROW_W-1:0]) * MAX_WIDTH + int'(r_col));
    assign px_addr = ADDR_W'(int'(r_row) * MAX_WIDTH + int'(r_col));

    // writes land the cycle the pixel is taken, so later reads always see them
    assign ram_we    = (r_state == ST_CLEAR) || pix_accept;
    assign ram_waddr = (r_state == ST_CLEAR) ? r_clr_addr : px_addr;
    assign ram_wdata = (r_state == ST_CLEAR) ? '0 : i_pix.pixel_value;

    rofdm_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_prev_frame (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (pix_accept && cmp_en),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    assign diff    = (r_s1_pix >= ram_rdata) ? (r_s1_pix - ram_rdata) : (ram_rdata - r_s1_pix);
    assign hit     = r_s1_cmp && (diff >= r_pix_thr) && (r_count != COUNT_MAX);
    assign n_count = r_count + COUNT_W'(hit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
            r_pix_thr      <= PIX_THR_RST;
            r_motion_thr   <= MOTION_THR_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_FRAME_WIDTH: begin
                    r_frame_width <= i_cfg.data[FW_W-1:0];
                end
                CFG_FRAME_HEIGHT: begin
                    r_frame_height <= i_cfg.data[FH_W-1:0];
                end
                CFG_PIX_THR: begin
                    r_pix_thr <= i_cfg.data[THR_W-1:0];
                end
                CFG_MOTION_THR: begin
                    r_motion_thr <= i_cfg.data[COUNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + ADDR_W'(1);
                    if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                end
                default: begin
                    r_state <= ST_CLEAR;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (pix_accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (!s1_stall) begin
                r_s1_valid <= pix_accept;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_accept) begin
            r_s1_pix  <= i_pix.pixel_value;
            r_s1_cmp  <= cmp_en;
            r_s1_last <= col_end && row_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_fire) begin
                r_count <= r_s1_last ? '0 : n_count;
            end
            if (s1_fire && r_s1_last) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && r_s1_last) begin
            r_out_count  <= n_count;
            r_out_motion <= n_count >= r_motion_thr;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.changed_count   = r_out_count;
    assign o_res.motion_detected = r_out_motion;

`include "row_offset_frame_difference_motion_assert.svh"

    `ROFDM_ASSERT_SAME(a_no_pixel_in_clear, r_state == ST_CLEAR, !i_pix.ready,
        "pixel request taken while the store is being cleared")
    `ROFDM_ASSERT_NEXT(a_accept_reaches_cmp, pix_accept, r_s1_valid,
        "accepted pixel request did not reach the compare stage")
    `ROFDM_ASSERT_NEXT(a_frame_end_result, s1_fire && r_s1_last,
        r_out_valid && (r_count == '0),
        "frame end did not load the result or clear the count")

endmodule

`default_nettype wire
